// ===== hw/rtl/lru_page_buffer_pool_defines.svh =====
// Assertion macros for the page buffer pool RTL.
`ifndef LRU_PAGE_BUFFER_POOL_DEFINES_SVH
`define LRU_PAGE_BUFFER_POOL_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define LPBP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define LPBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lpbp_pkg.sv =====
// Shared codes and control structs for the page buffer pool.
package lpbp_pkg;

    localparam logic [1:0] OP_FETCH = 2'd0;
    localparam logic [1:0] OP_UNPIN = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    localparam logic [2:0] ST_HIT         = 3'd0;
    localparam logic [2:0] ST_LOAD_FREE   = 3'd1;
    localparam logic [2:0] ST_LOAD_EVICT  = 3'd2;
    localparam logic [2:0] ST_ALL_PINNED  = 3'd3;
    localparam logic [2:0] ST_UNPINNED    = 3'd4;
    localparam logic [2:0] ST_ABSENT      = 3'd5;
    localparam logic [2:0] ST_FLUSH_WRITE = 3'd6;
    localparam logic [2:0] ST_NO_DIRTY    = 3'd7;

    typedef struct packed {
        logic load;        // input beat taken
        logic scan_step;   // examine frame at idx
        logic apply;       // commit fetch/unpin and load result
        logic flush_emit;  // write out frame at idx, clear its dirty mark
        logic flush_none;  // emit the nothing-dirty result
    } lpbp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic dirty_here;
        logic dirty_after;
    } lpbp_stat_t;

endpackage

// ===== hw/rtl/lpbp_ctrl.sv =====
// Sequencer for scan, commit and flush walks of the page buffer pool.
module lpbp_ctrl #(
    parameter int FRAMES = 16,
    parameter int IDX_W  = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           opcode,
    input  lpbp_pkg::lpbp_stat_t stat,
    output lpbp_pkg::lpbp_cmd_t  cmd,
    output logic [IDX_W-1:0]     idx
);
    import lpbp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_FLUSH,
        S_FLUSH_NONE
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAMES - 1);

    state_t           state_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             saw_reg;

    assign in_ready = (state_reg == S_IDLE);
    assign idx      = idx_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.load       = in_valid && in_ready;
        cmd.scan_step  = (state_reg == S_SCAN);
        cmd.apply      = (state_reg == S_APPLY) && stat.out_free;
        cmd.flush_emit = (state_reg == S_FLUSH) && stat.dirty_here && stat.out_free;
        cmd.flush_none = (state_reg == S_FLUSH_NONE) && stat.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            saw_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.load)
                    begin
                        idx_reg <= '0;
                        saw_reg <= 1'b0;
                        if (opcode == OP_FETCH || opcode == OP_UNPIN)
                            state_reg <= S_SCAN;
                        else if (opcode == OP_FLUSH)
                            state_reg <= S_FLUSH;
                    end
                end
                S_SCAN:
                begin
                    if (idx_reg == LAST_IDX)
                        state_reg <= S_APPLY;
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_APPLY:
                begin
                    if (cmd.apply)
                        state_reg <= S_IDLE;
                end
                S_FLUSH:
                begin
                    // hold on a dirty frame until the output register frees up
                    if (!stat.dirty_here || stat.out_free)
                    begin
                        if (stat.dirty_here)
                            saw_reg <= 1'b1;
                        if (idx_reg == LAST_IDX)
                            state_reg <= (saw_reg || stat.dirty_here) ? S_IDLE : S_FLUSH_NONE;
                        else
                            idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_FLUSH_NONE:
                begin
                    if (cmd.flush_none)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/lpbp_datapath.sv =====
// Frame table, scan trackers and result register of the page buffer pool.
`include "lru_page_buffer_pool_defines.svh"

module lpbp_datapath #(
    parameter int FRAMES       = 16,
    parameter int PAGE_ID_BITS = 31,
    parameter int PIN_BITS     = 16,
    parameter int IDX_W        = 4,
    parameter int CNT_W        = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [CNT_W-1:0]        cfg_wr_data,
    input  logic [1:0]              opcode,
    input  logic [PAGE_ID_BITS-1:0] page_id,
    input  logic                    mark_dirty,
    input  lpbp_pkg::lpbp_cmd_t     cmd,
    input  logic [IDX_W-1:0]        idx,
    output lpbp_pkg::lpbp_stat_t    stat,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [2:0]              status,
    output logic [IDX_W-1:0]        frame,
    output logic                    read_needed,
    output logic                    write_needed,
    output logic [PAGE_ID_BITS-1:0] write_page,
    output logic [PIN_BITS-1:0]     pins_now,
    output logic                    last
);
    import lpbp_pkg::*;

    localparam logic [CNT_W-1:0]    FRAMES_C = CNT_W'(FRAMES);
    localparam logic [PIN_BITS-1:0] PIN_ONE  = PIN_BITS'(1);

    // frame table: one row of cells per frame
    logic                    valid_reg [FRAMES];
    logic [PAGE_ID_BITS-1:0] page_reg  [FRAMES];
    logic [PIN_BITS-1:0]     pins_reg  [FRAMES];
    logic                    dirty_reg [FRAMES];
    logic [IDX_W-1:0]        rec_reg   [FRAMES];
    logic                    valid_next [FRAMES];
    logic [PIN_BITS-1:0]     pins_next  [FRAMES];
    logic                    dirty_next [FRAMES];
    logic [IDX_W-1:0]        rec_next   [FRAMES];
    logic                    load_lane  [FRAMES];
    logic [CNT_W-1:0]        resident_reg, resident_next;
    logic [CNT_W-1:0]        fiu_reg;

    // latched item
    logic [1:0]              op_reg;
    logic [PAGE_ID_BITS-1:0] want_reg;
    logic                    md_reg;

    // scan trackers
    logic                    hit_reg, free_reg, vic_reg;
    logic [IDX_W-1:0]        hit_idx_reg, free_idx_reg, vic_idx_reg;
    logic [IDX_W-1:0]        hit_rec_reg, vic_rec_reg;
    logic [PIN_BITS-1:0]     hit_pins_reg;
    logic                    vic_dirty_reg;
    logic [PAGE_ID_BITS-1:0] vic_page_reg;

    // result register
    logic                    out_valid_reg;
    logic [2:0]              status_reg, r_status;
    logic [IDX_W-1:0]        frame_reg, r_frame;
    logic                    read_reg, r_read;
    logic                    write_reg, r_write;
    logic [PAGE_ID_BITS-1:0] wpage_reg, r_wpage;
    logic [PIN_BITS-1:0]     pins_out_reg, r_pins;
    logic                    last_reg, r_last;

    logic [CNT_W-1:0]    eff_frames;
    logic                full, do_evict, do_free;
    logic [PIN_BITS-1:0] hit_inc, hit_dec;
    logic [FRAMES-1:0]   vd_vec, above_vec;
    logic                load_out;

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign frame        = frame_reg;
    assign read_needed  = read_reg;
    assign write_needed = write_reg;
    assign write_page   = wpage_reg;
    assign pins_now     = pins_out_reg;
    assign last         = last_reg;

    always_comb
    begin
        if (fiu_reg == '0)
            eff_frames = CNT_W'(1);
        else if (fiu_reg > FRAMES_C)
            eff_frames = FRAMES_C;
        else
            eff_frames = fiu_reg;
    end

    assign full     = (resident_reg >= eff_frames);
    assign do_evict = full && vic_reg;
    assign do_free  = !full && free_reg;
    assign hit_inc  = (hit_pins_reg == '1) ? hit_pins_reg : hit_pins_reg + PIN_ONE;
    assign hit_dec  = (hit_pins_reg == '0) ? hit_pins_reg : hit_pins_reg - PIN_ONE;

    always_comb
    begin
        for (int j = 0; j < FRAMES; j++)
        begin
            vd_vec[j]    = valid_reg[j] && dirty_reg[j];
            above_vec[j] = (IDX_W'(j) > idx);
        end
    end

    assign stat.out_free    = !out_valid_reg || out_ready;
    assign stat.dirty_here  = vd_vec[idx];
    assign stat.dirty_after = |(vd_vec & above_vec);

    // result of a fetch or unpin commit, a flush write or the nothing-dirty beat
    always_comb
    begin
        r_status = ST_ALL_PINNED;
        r_frame  = '0;
        r_read   = 1'b0;
        r_write  = 1'b0;
        r_wpage  = '0;
        r_pins   = '0;
        r_last   = 1'b1;
        if (cmd.flush_emit)
        begin
            r_status = ST_FLUSH_WRITE;
            r_frame  = idx;
            r_write  = 1'b1;
            r_wpage  = page_reg[idx];
            r_pins   = pins_reg[idx];
            r_last   = !stat.dirty_after;
        end
        else if (cmd.flush_none)
        begin
            r_status = ST_NO_DIRTY;
        end
        else if (op_reg == OP_FETCH)
        begin
            if (hit_reg)
            begin
                r_status = ST_HIT;
                r_frame  = hit_idx_reg;
                r_pins   = hit_inc;
            end
            else if (do_evict)
            begin
                r_status = ST_LOAD_EVICT;
                r_frame  = vic_idx_reg;
                r_read   = 1'b1;
                r_write  = vic_dirty_reg;
                r_wpage  = vic_dirty_reg ? vic_page_reg : '0;
                r_pins   = PIN_ONE;
            end
            else if (do_free)
            begin
                r_status = ST_LOAD_FREE;
                r_frame  = free_idx_reg;
                r_read   = 1'b1;
                r_pins   = PIN_ONE;
            end
        end
        else
        begin
            if (hit_reg)
            begin
                r_status = ST_UNPINNED;
                r_frame  = hit_idx_reg;
                r_pins   = hit_dec;
            end
            else
            begin
                r_status = ST_ABSENT;
            end
        end
    end

    assign load_out = cmd.apply || cmd.flush_emit || cmd.flush_none;

    // per-frame next state
    always_comb
    begin
        resident_next = resident_reg;
        if (cmd.apply && op_reg == OP_FETCH && !hit_reg && do_free)
            resident_next = resident_reg + 1'b1;
        for (int j = 0; j < FRAMES; j++)
        begin
            valid_next[j] = valid_reg[j];
            pins_next[j]  = pins_reg[j];
            dirty_next[j] = dirty_reg[j];
            rec_next[j]   = rec_reg[j];
            load_lane[j]  = 1'b0;
            if (cmd.apply && op_reg == OP_FETCH)
            begin
                if (hit_reg)
                begin
                    if (IDX_W'(j) == hit_idx_reg)
                    begin
                        rec_next[j]  = '0;
                        pins_next[j] = hit_inc;
                    end
                    else if (valid_reg[j] && rec_reg[j] < hit_rec_reg)
                        rec_next[j] = rec_reg[j] + 1'b1;
                end
                else if (do_evict)
                begin
                    // frames more recent than the victim age by one; the victim reloads at rank zero
                    if (IDX_W'(j) == vic_idx_reg)
                        load_lane[j] = 1'b1;
                    else if (valid_reg[j] && rec_reg[j] < vic_rec_reg)
                        rec_next[j] = rec_reg[j] + 1'b1;
                end
                else if (do_free)
                begin
                    if (IDX_W'(j) == free_idx_reg)
                        load_lane[j] = 1'b1;
                    else if (valid_reg[j])
                        rec_next[j] = rec_reg[j] + 1'b1;
                end
            end
            else if (cmd.apply && op_reg == OP_UNPIN)
            begin
                if (hit_reg && IDX_W'(j) == hit_idx_reg)
                begin
                    dirty_next[j] = dirty_reg[j] | md_reg;
                    pins_next[j]  = hit_dec;
                end
            end
            if (cmd.flush_emit && IDX_W'(j) == idx)
                dirty_next[j] = 1'b0;
            if (load_lane[j])
            begin
                valid_next[j] = 1'b1;
                pins_next[j]  = PIN_ONE;
                dirty_next[j] = 1'b0;
                rec_next[j]   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < FRAMES; j++)
            begin
                valid_reg[j] <= 1'b0;
                pins_reg[j]  <= '0;
                dirty_reg[j] <= 1'b0;
                rec_reg[j]   <= '0;
            end
            resident_reg  <= '0;
            fiu_reg       <= FRAMES_C;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            vic_reg       <= 1'b0;
        end
        else
        begin
            for (int j = 0; j < FRAMES; j++)
            begin
                valid_reg[j] <= valid_next[j];
                pins_reg[j]  <= pins_next[j];
                dirty_reg[j] <= dirty_next[j];
                rec_reg[j]   <= rec_next[j];
            end
            resident_reg <= resident_next;
            if (cfg_wr_en)
                fiu_reg <= cfg_wr_data;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.load)
            begin
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
                vic_reg  <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                if (valid_reg[idx] && page_reg[idx] == want_reg && !hit_reg)
                    hit_reg <= 1'b1;
                if (!valid_reg[idx] && !free_reg)
                    free_reg <= 1'b1;
                if (valid_reg[idx] && pins_reg[idx] == '0
                    && (!vic_reg || rec_reg[idx] > vic_rec_reg))
                    vic_reg <= 1'b1;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < FRAMES; j++)
        begin
            if (load_lane[j])
                page_reg[j] <= want_reg;
        end
        if (cmd.load)
        begin
            op_reg   <= opcode;
            want_reg <= page_id;
            md_reg   <= mark_dirty;
        end
        if (cmd.scan_step)
        begin
            if (valid_reg[idx] && page_reg[idx] == want_reg && !hit_reg)
            begin
                hit_idx_reg  <= idx;
                hit_rec_reg  <= rec_reg[idx];
                hit_pins_reg <= pins_reg[idx];
            end
            if (!valid_reg[idx] && !free_reg)
                free_idx_reg <= idx;
            if (valid_reg[idx] && pins_reg[idx] == '0
                && (!vic_reg || rec_reg[idx] > vic_rec_reg))
            begin
                vic_idx_reg   <= idx;
                vic_rec_reg   <= rec_reg[idx];
                vic_dirty_reg <= dirty_reg[idx];
                vic_page_reg  <= page_reg[idx];
            end
        end
        if (load_out)
        begin
            status_reg   <= r_status;
            frame_reg    <= r_frame;
            read_reg     <= r_read;
            write_reg    <= r_write;
            wpage_reg    <= r_wpage;
            pins_out_reg <= r_pins;
            last_reg     <= r_last;
        end
    end

    logic [FRAMES-1:0] valid_vec;
    always_comb
    begin
        for (int j = 0; j < FRAMES; j++)
            valid_vec[j] = valid_reg[j];
    end

    `LPBP_ASSERT_NOW(a_res_matches_valid, clk, rst_n, 1'b1,
        $countones(valid_vec) == int'(resident_reg), "resident count out of step with valid frames")
    `LPBP_ASSERT_NOW(a_load_needs_room, clk, rst_n, load_out,
        !out_valid_reg || out_ready, "result loaded over an untaken beat")
    `LPBP_ASSERT_NOW(a_emit_is_dirty, clk, rst_n, cmd.flush_emit,
        vd_vec[idx], "flush write for a clean frame")
    `LPBP_ASSERT_NEXT(a_emit_clears, clk, rst_n, cmd.flush_emit,
        !dirty_reg[$past(idx)], "dirty mark kept after flush write")

endmodule

// ===== hw/rtl/lru_page_buffer_pool.sv =====
// Top level of the LRU page buffer pool: frame table with pin counts and dirty marks.
//
// Input channel (in_valid/in_ready) takes one beat of opcode, page_id, mark_dirty.
// Fetch and unpin scan the frame table one frame per cycle, then commit and load
// the result register, one result beat each. A flush walks the frames one per
// cycle and emits one beat per dirty frame in frame order, or one nothing-dirty
// beat, with last set on the final beat. Opcode 3 is dropped with no result.
// in_ready is high only between items, so a new item waits until the last one
// has committed. The output register lets a new item be taken and scanned
// while the previous result still waits for out_ready.
// When the receiver stalls, the commit, or the flush walk at a dirty frame, holds
// until the result register frees; state is not touched until then.
// cfg_wr_en/cfg_wr_data write frames_in_use (0 acts as 1, above FRAMES as
// FRAMES); write it only while the block is idle.
// Reset (rst_n low) empties all frames and sets frames_in_use to FRAMES.
module lru_page_buffer_pool #(
    parameter int FRAMES       = 16,
    parameter int PAGE_ID_BITS = 31,
    parameter int PIN_BITS     = 16,
    parameter int IDX_W        = (FRAMES > 1) ? $clog2(FRAMES) : 1,
    parameter int CNT_W        = $clog2(FRAMES + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [CNT_W-1:0]        cfg_wr_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              opcode,
    input  logic [PAGE_ID_BITS-1:0] page_id,
    input  logic                    mark_dirty,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [2:0]              status,
    output logic [IDX_W-1:0]        frame,
    output logic                    read_needed,
    output logic                    write_needed,
    output logic [PAGE_ID_BITS-1:0] write_page,
    output logic [PIN_BITS-1:0]     pins_now,
    output logic                    last
);
    import lpbp_pkg::*;

    lpbp_cmd_t        cmd;
    lpbp_stat_t       stat;
    logic [IDX_W-1:0] idx;

    lpbp_ctrl #(
        .FRAMES (FRAMES),
        .IDX_W  (IDX_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (opcode),
        .stat     (stat),
        .cmd      (cmd),
        .idx      (idx)
    );

    lpbp_datapath #(
        .FRAMES       (FRAMES),
        .PAGE_ID_BITS (PAGE_ID_BITS),
        .PIN_BITS     (PIN_BITS),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .opcode       (opcode),
        .page_id      (page_id),
        .mark_dirty   (mark_dirty),
        .cmd          (cmd),
        .idx          (idx),
        .stat         (stat),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .frame        (frame),
        .read_needed  (read_needed),
        .write_needed (write_needed),
        .write_page   (write_page),
        .pins_now     (pins_now),
        .last         (last)
    );

endmodule
